[rtl/itn_pkg.sv]
// Shared types and constants for the quadrature tone oscillator.
package itn_pkg;

    localparam int LEN_W      = 7;
    localparam int STEP_W     = 32;
    localparam int AMP_W      = 15;
    localparam int MAG_W      = 15;
    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = MAG_W + AMP_W;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [STEP_W-1:0] STEP_RESET = 32'd139810133;
    localparam logic [AMP_W-1:0]  AMP_RESET  = 15'd16000;

    // pi/2 in Q30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic {
        REG_PHASE_STEP = 1'b0,
        REG_AMPLITUDE  = 1'b1
    } reg_idx_t;

    // Sideband that travels beside the table read data.
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [1:0] quad;
    } itn_ctrl_t;

endpackage

[rtl/itn_if.sv]
// Stream interfaces for burst requests and IQ sample beats.
interface itn_burst_if
    import itn_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] burst_length;

    modport source (output valid, output burst_length, input ready);
    modport sink   (input valid, input burst_length, output ready);
endinterface

interface itn_iq_if
    import itn_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic signed [SAMPLE_W-1:0] q_sample;
    logic                       burst_last;

    modport source (output valid, output i_sample, output q_sample, output burst_last,
                    input ready);
    modport sink   (input valid, input i_sample, input q_sample, input burst_last,
                    output ready);
endinterface

[rtl/iq_tone_nco.sv]
// Quadrature tone generator: burst sequencer, phase accumulator, sine ROM and scaler.
// A request beat loads the burst counter; its samples then pass the ROM read, product and output registers.
// Throughput: one sample per cycle while the output is not stalled; a burst of L samples (L saturated
// to MAX_BURST) holds the request channel until all L samples have issued, and only then is a new request taken.
// The two-port sine ROM read and the amplitude multiply each take one pipe stage.
// Reset: phase and sample count clear to zero, registers take their defaults.
module iq_tone_nco
    import itn_pkg::*;
#(
    parameter int MAX_BURST       = 64,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int PHASE_BITS      = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    itn_burst_if.sink             in_ch,
    itn_iq_if.source              out_ch
);

    localparam int SUM_W = PHASE_BITS + STEP_W;

    logic [STEP_W-1:0]          phase_step;
    logic [AMP_W-1:0]           amplitude;
    logic [LEN_W-1:0]           cnt_reg;
    logic [LEN_W-1:0]           cnt_next;
    logic [PHASE_BITS-1:0]      phase_reg;
    logic [PHASE_BITS-1:0]      phase_next;
    logic [SUM_W-1:0]           phase_sum;
    logic [LEN_W-1:0]           req_len;
    logic                       accept;
    logic                       issue;
    logic                       advance;
    itn_ctrl_t                  s1_ctrl_reg;
    logic [MAG_W-1:0]           a_mag;
    logic [MAG_W-1:0]           b_mag;
    logic [TABLE_ADDR_BITS-1:0] rom_idx;

    itn_apb_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .phase_step (phase_step),
        .amplitude  (amplitude)
    );

    // Take a new request only once the previous burst has fully issued.
    // A zero length request is taken and produces nothing.
    assign in_ch.ready = (cnt_reg == '0);
    assign accept      = in_ch.valid && in_ch.ready;
    assign issue       = (cnt_reg != '0) && advance;

    // Clip the request to the longest burst.
    assign req_len = (in_ch.burst_length > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST)
                                                              : in_ch.burst_length;

    // Phase wraps modulo 2^PHASE_BITS; the step is added as is and the sum masked.
    assign phase_sum = SUM_W'(phase_reg) + SUM_W'(phase_step);

    // Table index: the phase bits right below the two quadrant bits.
    assign rom_idx = phase_reg[PHASE_BITS-3 -: TABLE_ADDR_BITS];

    always_comb
    begin
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        if (accept)
        begin
            cnt_next = req_len;
        end
        else if (issue)
        begin
            cnt_next   = cnt_reg - LEN_W'(1);
            phase_next = phase_sum[PHASE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            phase_reg   <= '0;
            s1_ctrl_reg <= '0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            // sideband moves in step with the ROM read registers
            if (advance)
            begin
                s1_ctrl_reg.valid <= issue;
                s1_ctrl_reg.last  <= (cnt_reg == LEN_W'(1));
                s1_ctrl_reg.quad  <= phase_reg[PHASE_BITS-1 -: 2];
            end
        end
    end

    itn_sine_rom #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_rom (
        .clk   (clk),
        .en    (advance),
        .idx   (rom_idx),
        .a_mag (a_mag),
        .b_mag (b_mag)
    );

    // Fold the quadrant, scale by amplitude, truncate toward zero, drive the beat.
    itn_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (s1_ctrl_reg),
        .a_mag     (a_mag),
        .b_mag     (b_mag),
        .amplitude (amplitude),
        .advance   (advance),
        .out_ch    (out_ch)
    );

    // A nonempty request starts a burst.
    a_burst_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_ch.burst_length != '0) |=> cnt_reg != '0)
        else $error("nonempty request did not start a burst");

    // Every issued sample enters the ROM stage.
    a_issue_enters: assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> s1_ctrl_reg.valid)
        else $error("issued sample lost before ROM stage");

    // The final issue of a burst carries the last mark and ends the burst.
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        issue && (cnt_reg == LEN_W'(1)) |=> (cnt_reg == '0) && s1_ctrl_reg.last)
        else $error("burst end and last mark disagree");

endmodule

[rtl/itn_apb_regs.sv]
// APB register file: phase step and amplitude.
module itn_apb_regs
    import itn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [STEP_W-1:0]     phase_step,
    output logic [AMP_W-1:0]      amplitude
);

    logic [STEP_W-1:0] step_reg;
    logic [AMP_W-1:0]  amp_reg;
    logic              wr_en;
    reg_idx_t          idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
            amp_reg  <= AMP_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_PHASE_STEP: step_reg <= pwdata[STEP_W-1:0];
                REG_AMPLITUDE:  amp_reg  <= pwdata[AMP_W-1:0];
                default:        step_reg <= step_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_PHASE_STEP: prdata = APB_DATA_W'(step_reg);
            REG_AMPLITUDE:  prdata = APB_DATA_W'(amp_reg);
            default:        prdata = '0;
        endcase
    end

    assign phase_step = step_reg;
    assign amplitude  = amp_reg;

endmodule

[rtl/itn_sine_rom.sv]
// Quarter-wave sine ROM with two registered read ports.
module itn_sine_rom
    import itn_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = 10
)
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [TABLE_ADDR_BITS-1:0] idx,
    output logic [MAG_W-1:0]           a_mag,
    output logic [MAG_W-1:0]           b_mag
);

    localparam int N      = 1 << TABLE_ADDR_BITS;
    localparam int ROM_AW = TABLE_ADDR_BITS + 1;

    typedef logic [MAG_W-1:0] rom_t [0:N];

    // Restoring shift-and-subtract quotient; only used while the table is built.
    function automatic longint unsigned long_div(input longint unsigned num,
                                                 input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // round(32768*sin(pi/2*k/N)) by a Q30 Taylor series, clipped to 32767
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k);
        longint unsigned x;
        longint unsigned term;
        longint unsigned div;
        longint          sum;
        longint          r;
        x    = (HALF_PI_Q30 * longint'(k)) >> TABLE_ADDR_BITS;
        term = x;
        sum  = longint'(x);
        for (int unsigned n = 1; n <= 7; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            div  = longint'((2 * n) * (2 * n + 1));
            term = long_div(term, div);
            if (n[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        r = (sum + 16384) >>> 15;
        if (r > 32767)
            r = 32767;
        return r[MAG_W-1:0];
    endfunction

    function automatic rom_t build_rom();
        rom_t t;
        for (int k = 0; k <= N; k++)
            t[k] = quarter_sine(k);
        return t;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [ROM_AW-1:0] a_addr;
    logic [ROM_AW-1:0] b_addr;
    logic [MAG_W-1:0]  a_reg;
    logic [MAG_W-1:0]  b_reg;

    assign a_addr = {1'b0, idx};
    assign b_addr = ROM_AW'(N) - a_addr;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= ROM[a_addr];
            b_reg <= ROM[b_addr];
        end
    end

    assign a_mag = a_reg;
    assign b_mag = b_reg;

endmodule

[rtl/itn_scale.sv]
// Quadrant fold, amplitude scaling and output register stage.
module itn_scale
    import itn_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  itn_ctrl_t       ctrl,
    input  logic [MAG_W-1:0] a_mag,
    input  logic [MAG_W-1:0] b_mag,
    input  logic [AMP_W-1:0] amplitude,
    output logic            advance,
    itn_iq_if.source        out_ch
);

    logic [MAG_W-1:0]  sin_mag;
    logic [MAG_W-1:0]  cos_mag;
    logic              p_valid_reg;
    logic              p_last_reg;
    logic              sin_neg_reg;
    logic              cos_neg_reg;
    logic [PROD_W-1:0] i_prod_reg;
    logic [PROD_W-1:0] q_prod_reg;
    logic [SAMPLE_W-1:0] i_mag;
    logic [SAMPLE_W-1:0] q_mag;
    logic              o_valid_reg;
    logic              o_last_reg;
    logic [SAMPLE_W-1:0] i_reg;
    logic [SAMPLE_W-1:0] q_reg;

    // hold the whole pipe while a beat waits at the output
    assign advance = !o_valid_reg || out_ch.ready;

    assign sin_mag = ctrl.quad[0] ? b_mag : a_mag;
    assign cos_mag = ctrl.quad[0] ? a_mag : b_mag;

    assign i_mag = SAMPLE_W'(i_prod_reg[PROD_W-1:AMP_W]);
    assign q_mag = SAMPLE_W'(q_prod_reg[PROD_W-1:AMP_W]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p_valid_reg <= ctrl.valid;
            o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_last_reg  <= ctrl.last;
            sin_neg_reg <= ctrl.quad[1];
            cos_neg_reg <= ctrl.quad[1] ^ ctrl.quad[0];
            i_prod_reg  <= PROD_W'(cos_mag) * PROD_W'(amplitude);
            q_prod_reg  <= PROD_W'(sin_mag) * PROD_W'(amplitude);
            o_last_reg  <= p_last_reg;
            i_reg       <= cos_neg_reg ? SAMPLE_W'(0) - i_mag : i_mag;
            q_reg       <= sin_neg_reg ? SAMPLE_W'(0) - q_mag : q_mag;
        end
    end

    assign out_ch.valid      = o_valid_reg;
    assign out_ch.i_sample   = i_reg;
    assign out_ch.q_sample   = q_reg;
    assign out_ch.burst_last = o_last_reg;

endmodule
